FILE: design/montgomery_modular_exponentiation_macros.svh
// Assertion macros used by the checker of the modular exponentiation block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_MACROS_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mme_pkg.sv
package mme_pkg;

    localparam int DATA_W        = 64;
    localparam int WIDTH_DEFAULT = 64;
    localparam int LIMB_W        = 32;
    localparam int NEWTON_STEPS  = 10;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    localparam logic [DATA_W-1:0] MODULUS_RESET  = 64'd1;
    localparam logic [DATA_W-1:0] EXPONENT_RESET = 64'd65537;

    // Datapath register updates requested by the controller.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_NP_INIT,
        ACT_NP_SET,
        ACT_CONV_INIT_MSG,
        ACT_CONV_INIT_ONE,
        ACT_CONV_STEP,
        ACT_ACC_FROM_R,
        ACT_T_SAVE,
        ACT_SUM_SAVE,
        ACT_ACC_SET,
        ACT_CIPHER_SET,
        ACT_OUT_WRITE
    } act_t;

    // Operand pairs fed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NEWTON_A,
        MUL_NEWTON_B,
        MUL_SQR,
        MUL_BASE,
        MUL_ONE,
        MUL_RED_M,
        MUL_RED_N
    } mul_sel_t;

    typedef struct packed {
        act_t     act;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     e_shift;
        logic     bad;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic n_odd;
        logic e_top;
        logic out_free;
    } status_t;

endpackage

FILE: design/mme_stream_if.sv
interface mme_req_if;
    import mme_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] message;
    logic              final_block;

    modport source (output valid, output message, output final_block, input ready);
    modport sink   (input valid, input message, input final_block, output ready);
endinterface

interface mme_rsp_if;
    import mme_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] cipher;
    logic              final_block_out;
    logic              bad_modulus;

    modport source (output valid, output cipher, output final_block_out,
                    output bad_modulus, input ready);
    modport sink   (input valid, input cipher, input final_block_out,
                    input bad_modulus, output ready);
endinterface

FILE: design/mme_mul.sv
module mme_mul #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic               done,
    output logic [2*WIDTH-1:0] product
);
    import mme_pkg::*;

    localparam int LIMBS = (WIDTH + LIMB_W - 1) / LIMB_W;
    localparam int OP_W  = LIMBS * LIMB_W;
    localparam int ACC_W = 2 * OP_W;
    localparam int IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int SH_W  = (LIMBS > 1) ? $clog2(2 * LIMBS - 1) : 1;

    logic [OP_W-1:0]     a_reg, a_next;
    logic [OP_W-1:0]     b_reg, b_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [SH_W-1:0]     sh_reg, sh_next;
    logic [2*LIMB_W-1:0] pp_reg, pp_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                busy_reg, busy_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic [LIMB_W-1:0]   a_limb;
    logic [LIMB_W-1:0]   b_limb;

    assign a_limb = a_reg[i_reg*LIMB_W +: LIMB_W];
    assign b_limb = b_reg[j_reg*LIMB_W +: LIMB_W];

    // One limb product per cycle; the registered product is added in the next cycle.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        sh_next   = sh_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        busy_next = busy_reg;
        pend_next = pend_reg;
        done_next = done_reg;
        if (start)
        begin
            a_next    = OP_W'(a);
            b_next    = OP_W'(b);
            i_next    = '0;
            j_next    = '0;
            acc_next  = '0;
            busy_next = 1'b1;
            pend_next = 1'b0;
            done_next = 1'b0;
        end
        else
        begin
            if (pend_reg)
            begin
                acc_next = acc_reg + (ACC_W'(pp_reg) << (sh_reg * LIMB_W));
            end
            pend_next = busy_reg;
            if (busy_reg)
            begin
                pp_next = a_limb * b_limb;
                sh_next = SH_W'(i_reg) + SH_W'(j_reg);
                if (j_reg == IDX_W'(LIMBS - 1))
                begin
                    j_next = '0;
                    if (i_reg == IDX_W'(LIMBS - 1))
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            if (pend_reg && !busy_reg)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            i_reg    <= i_next;
            j_reg    <= j_next;
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        sh_reg  <= sh_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[2*WIDTH-1:0];

endmodule

FILE: design/mme_dp.sv
module mme_dp #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mme_pkg::cmd_t    cmd,
    output mme_pkg::status_t status,
    input  logic [WIDTH-1:0] modulus,
    input  logic [WIDTH-1:0] exponent,
    input  logic [WIDTH-1:0] message,
    input  logic             final_block,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    output logic [WIDTH-1:0] cipher,
    output logic             final_block_out,
    output logic             bad_modulus
);
    import mme_pkg::*;

    logic [WIDTH-1:0]   msg_reg, msg_next;
    logic               flag_reg, flag_next;
    logic [WIDTH-1:0]   e_reg, e_next;
    logic [WIDTH-1:0]   np_reg, np_next;
    logic [WIDTH-1:0]   r_reg, r_next;
    logic [WIDTH-1:0]   x_reg, x_next;
    logic [WIDTH-1:0]   base_reg, base_next;
    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [2*WIDTH-1:0] t_reg, t_next;
    logic [WIDTH:0]     s_reg, s_next;
    logic [WIDTH-1:0]   res_reg, res_next;
    logic [WIDTH-1:0]   out_cipher_reg, out_cipher_next;
    logic               out_final_reg, out_final_next;
    logic               out_bad_reg, out_bad_next;
    logic               out_valid_reg, out_valid_next;

    logic [WIDTH-1:0]   mul_a;
    logic [WIDTH-1:0]   mul_b;
    logic               mul_done;
    logic [2*WIDTH-1:0] prod;
    logic [WIDTH-1:0]   prod_lo;
    logic [WIDTH-1:0]   conv_shift;
    logic [WIDTH-1:0]   conv_val;
    logic [2*WIDTH:0]   sum_full;
    logic [WIDTH:0]     red_diff;
    logic [WIDTH-1:0]   reduced;

    mme_mul #(.WIDTH(WIDTH)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    assign prod_lo = prod[WIDTH-1:0];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_NEWTON_A:
            begin
                mul_a = modulus;
                mul_b = np_reg;
            end
            MUL_NEWTON_B:
            begin
                mul_a = np_reg;
                mul_b = WIDTH'(2) - prod_lo;
            end
            MUL_SQR:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            MUL_BASE:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            MUL_ONE:
            begin
                mul_a = acc_reg;
                mul_b = WIDTH'(1);
            end
            MUL_RED_M:
            begin
                // The Newton steps leave the inverse of the modulus, so the
                // reduction factor takes its negation.
                mul_a = prod_lo;
                mul_b = WIDTH'(0) - np_reg;
            end
            MUL_RED_N:
            begin
                mul_a = prod_lo;
                mul_b = modulus;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Restoring reduction step: the bit shifted out of the remainder forces a subtract.
    assign conv_shift = {r_reg[WIDTH-2:0], x_reg[WIDTH-1]};
    assign conv_val   = (r_reg[WIDTH-1] || (conv_shift >= modulus))
                        ? (conv_shift - modulus) : conv_shift;

    // The Montgomery sum keeps its carry, so one conditional subtract fully reduces it.
    assign sum_full = {1'b0, t_reg} + {1'b0, prod};
    assign red_diff = s_reg - {1'b0, modulus};
    assign reduced  = (s_reg >= {1'b0, modulus}) ? red_diff[WIDTH-1:0] : s_reg[WIDTH-1:0];

    always_comb
    begin
        msg_next        = msg_reg;
        flag_next       = flag_reg;
        e_next          = e_reg;
        np_next         = np_reg;
        r_next          = r_reg;
        x_next          = x_reg;
        base_next       = base_reg;
        acc_next        = acc_reg;
        t_next          = t_reg;
        s_next          = s_reg;
        res_next        = res_reg;
        out_cipher_next = out_cipher_reg;
        out_final_next  = out_final_reg;
        out_bad_next    = out_bad_reg;
        out_valid_next  = out_valid_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (cmd.act)
            ACT_LOAD:
            begin
                msg_next  = message;
                flag_next = final_block;
                e_next    = exponent;
            end
            ACT_NP_INIT:       np_next = WIDTH'(1);
            ACT_NP_SET:        np_next = prod_lo;
            ACT_CONV_INIT_MSG:
            begin
                r_next = '0;
                x_next = msg_reg;
            end
            ACT_CONV_INIT_ONE:
            begin
                base_next = r_reg;
                r_next    = '0;
                x_next    = WIDTH'(1);
            end
            ACT_CONV_STEP:
            begin
                r_next = conv_val;
                x_next = x_reg << 1;
            end
            ACT_ACC_FROM_R:    acc_next = r_reg;
            ACT_T_SAVE:        t_next = prod;
            ACT_SUM_SAVE:      s_next = sum_full[2*WIDTH:WIDTH];
            ACT_ACC_SET:       acc_next = reduced;
            ACT_CIPHER_SET:    res_next = reduced;
            ACT_OUT_WRITE:
            begin
                out_cipher_next = cmd.bad ? '0 : res_reg;
                out_final_next  = flag_reg;
                out_bad_next    = cmd.bad;
                out_valid_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (cmd.e_shift)
        begin
            e_next = e_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg        <= msg_next;
        flag_reg       <= flag_next;
        e_reg          <= e_next;
        np_reg         <= np_next;
        r_reg          <= r_next;
        x_reg          <= x_next;
        base_reg       <= base_next;
        acc_reg        <= acc_next;
        t_reg          <= t_next;
        s_reg          <= s_next;
        res_reg        <= res_next;
        out_cipher_reg <= out_cipher_next;
        out_final_reg  <= out_final_next;
        out_bad_reg    <= out_bad_next;
    end

    assign status.mul_done = mul_done;
    assign status.n_odd    = modulus[0];
    assign status.e_top    = e_reg[WIDTH-1];
    assign status.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign cipher          = out_cipher_reg;
    assign final_block_out = out_final_reg;
    assign bad_modulus     = out_bad_reg;

endmodule

FILE: design/mme_ctrl.sv
module mme_ctrl #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output mme_pkg::cmd_t    cmd,
    input  mme_pkg::status_t status
);
    import mme_pkg::*;

    localparam int CNT_W = $clog2(2 * WIDTH);

    typedef enum logic [17:0] {
        S_IDLE          = 18'h00001,
        S_CHECK         = 18'h00002,
        S_NWT_A         = 18'h00004,
        S_NWT_A_WAIT    = 18'h00008,
        S_NWT_B_WAIT    = 18'h00010,
        S_CONV_MSG_INIT = 18'h00020,
        S_CONV_MSG      = 18'h00040,
        S_CONV_ONE_INIT = 18'h00080,
        S_CONV_ONE      = 18'h00100,
        S_LOOP_INIT     = 18'h00200,
        S_SQR           = 18'h00400,
        S_MUL           = 18'h00800,
        S_ONE           = 18'h01000,
        S_MM_T          = 18'h02000,
        S_MM_M          = 18'h04000,
        S_MM_N          = 18'h08000,
        S_MM_FIN        = 18'h10000,
        S_FINISH        = 18'h20000
    } state_t;

    typedef enum logic [1:0] {
        KIND_SQR,
        KIND_MUL,
        KIND_ONE
    } kind_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             bad_reg, bad_next;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cnt_next      = cnt_reg;
        bad_next      = bad_reg;
        req_ready     = 1'b0;
        cmd.act       = ACT_NONE;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = MUL_SQR;
        cmd.e_shift   = 1'b0;
        cmd.bad       = bad_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.act    = ACT_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.n_odd)
                begin
                    bad_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    bad_next   = 1'b0;
                    cmd.act    = ACT_NP_INIT;
                    cnt_next   = '0;
                    state_next = S_NWT_A;
                end
            end
            S_NWT_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_NEWTON_A;
                state_next    = S_NWT_A_WAIT;
            end
            S_NWT_A_WAIT:
            begin
                cmd.mul_sel = MUL_NEWTON_B;
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_NWT_B_WAIT;
                end
            end
            S_NWT_B_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.act = ACT_NP_SET;
                    if (cnt_reg == CNT_W'(NEWTON_STEPS - 1))
                    begin
                        state_next = S_CONV_MSG_INIT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_NWT_A;
                    end
                end
            end
            S_CONV_MSG_INIT:
            begin
                cmd.act    = ACT_CONV_INIT_MSG;
                cnt_next   = '0;
                state_next = S_CONV_MSG;
            end
            S_CONV_MSG:
            begin
                cmd.act = ACT_CONV_STEP;
                if (cnt_reg == CNT_W'(2 * WIDTH - 1))
                begin
                    state_next = S_CONV_ONE_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CONV_ONE_INIT:
            begin
                cmd.act    = ACT_CONV_INIT_ONE;
                cnt_next   = '0;
                state_next = S_CONV_ONE;
            end
            S_CONV_ONE:
            begin
                cmd.act = ACT_CONV_STEP;
                if (cnt_reg == CNT_W'(2 * WIDTH - 1))
                begin
                    state_next = S_LOOP_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LOOP_INIT:
            begin
                cmd.act    = ACT_ACC_FROM_R;
                cnt_next   = '0;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SQR;
                kind_next     = KIND_SQR;
                state_next    = S_MM_T;
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_BASE;
                kind_next     = KIND_MUL;
                state_next    = S_MM_T;
            end
            S_ONE:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_ONE;
                kind_next     = KIND_ONE;
                state_next    = S_MM_T;
            end
            S_MM_T:
            begin
                cmd.mul_sel = MUL_RED_M;
                if (status.mul_done)
                begin
                    cmd.act       = ACT_T_SAVE;
                    cmd.mul_start = 1'b1;
                    state_next    = S_MM_M;
                end
            end
            S_MM_M:
            begin
                cmd.mul_sel = MUL_RED_N;
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MM_N;
                end
            end
            S_MM_N:
            begin
                if (status.mul_done)
                begin
                    cmd.act    = ACT_SUM_SAVE;
                    state_next = S_MM_FIN;
                end
            end
            S_MM_FIN:
            begin
                case (kind_reg)
                    KIND_ONE:
                    begin
                        cmd.act    = ACT_CIPHER_SET;
                        state_next = S_FINISH;
                    end
                    KIND_SQR:
                    begin
                        cmd.act = ACT_ACC_SET;
                        if (status.e_top)
                        begin
                            state_next = S_MUL;
                        end
                        else
                        begin
                            cmd.e_shift = 1'b1;
                            if (cnt_reg == CNT_W'(WIDTH - 1))
                            begin
                                state_next = S_ONE;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_SQR;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.act     = ACT_ACC_SET;
                        cmd.e_shift = 1'b1;
                        if (cnt_reg == CNT_W'(WIDTH - 1))
                        begin
                            state_next = S_ONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_SQR;
                        end
                    end
                endcase
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.act    = ACT_OUT_WRITE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_SQR;
            cnt_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

FILE: design/montgomery_modular_exponentiation.sv
// Modular exponentiation engine: each request carries a message block and returns
// cipher = message^exponent mod modulus, with modulus and exponent taken from the
// configuration registers (index 0 is the modulus, reset 1; index 1 is the exponent,
// reset 65537; only their low WIDTH bits are used, as are the low WIDTH bits of the
// message). The modulus must be odd: an even modulus, zero included, returns a cipher
// of zero with bad_modulus set and does no arithmetic. The final_block marker is
// returned unchanged with its result. Requests are processed one at a time. All
// arithmetic runs on one shared multiplier that forms a 32 x 32 bit limb product each
// cycle, so a WIDTH x WIDTH multiplication takes L*L limb products, where
// L = ceil(WIDTH/32). For an odd modulus, ten Newton steps derive
// modulus^-1 mod 2^WIDTH, two bit-serial reductions bring the message and one
// into Montgomery form, and each Montgomery product costs three multiplications.
// A finished result sits in an output register, so the next request is accepted
// while the previous result still waits to be taken. Configuration writes are
// expected only while the block is idle.
module montgomery_modular_exponentiation #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mme_req_if.sink                        request,
    mme_rsp_if.source                      response,
    input  logic                           cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mme_pkg::DATA_W-1:0]     cfg_data
);
    import mme_pkg::*;

    // The configuration registers keep the full written value; the datapath sees
    // only the low WIDTH bits.
    logic [DATA_W-1:0] modulus_reg, modulus_next;
    logic [DATA_W-1:0] exponent_reg, exponent_next;

    cmd_t              cmd;
    status_t           status;
    logic              req_ready;
    logic              rsp_valid;
    logic [WIDTH-1:0]  cipher_w;
    logic              final_w;
    logic              bad_w;

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS:  modulus_next  = cfg_data;
                CFG_EXPONENT: exponent_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else
        begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    // The controller sequences the Newton steps, the conversions into Montgomery
    // form, the square-and-multiply scan from the top exponent bit down and the
    // final conversion back; the datapath holds the operands and the multiplier.
    mme_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .status    (status)
    );

    mme_dp #(.WIDTH(WIDTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .modulus         (modulus_reg[WIDTH-1:0]),
        .exponent        (exponent_reg[WIDTH-1:0]),
        .message         (request.message[WIDTH-1:0]),
        .final_block     (request.final_block),
        .rsp_ready       (response.ready),
        .rsp_valid       (rsp_valid),
        .cipher          (cipher_w),
        .final_block_out (final_w),
        .bad_modulus     (bad_w)
    );

    assign request.ready            = req_ready;
    assign response.valid           = rsp_valid;
    assign response.cipher          = DATA_W'(cipher_w);
    assign response.final_block_out = final_w;
    assign response.bad_modulus     = bad_w;

endmodule

FILE: design/mme_checker.sv
`include "montgomery_modular_exponentiation_macros.svh"

module mme_checker #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [mme_pkg::DATA_W-1:0] cipher,
    input logic                       final_block_out,
    input logic                       bad_modulus
);

    // An even modulus must never produce a non-zero cipher.
    `MME_ASSERT_SAME(a_bad_zero, rsp_valid && bad_modulus, cipher == '0, "bad modulus with non-zero cipher")

    // The cipher is reduced below a WIDTH-bit modulus, so no bit above WIDTH is set.
    `MME_ASSERT_SAME(a_cipher_width, rsp_valid, (cipher >> WIDTH) == '0, "cipher wider than WIDTH")

    // Only one request is in work at a time: acceptance closes the request side.
    `MME_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request accepted twice in a row")

    // A stalled result stays in place.
    `MME_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(cipher) && $stable(bad_modulus) && $stable(final_block_out), "stalled result changed")

endmodule

bind montgomery_modular_exponentiation mme_checker #(.WIDTH(WIDTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .rsp_valid       (response.valid),
    .rsp_ready       (response.ready),
    .cipher          (response.cipher),
    .final_block_out (response.final_block_out),
    .bad_modulus     (response.bad_modulus)
);
